// ===== rtl/core/rssa_pkg.sv =====
`timescale 1ns / 1ps

package rssa_pkg;

  // pool geometry
  localparam int MAX_SLOTS  = 64;
  localparam int COORD_BITS = 16;
  localparam int LOC_W      = 2 * COORD_BITS;
  localparam int IDX_W      = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W      = $clog2(MAX_SLOTS + 1);
  localparam int ALU_W      = CNT_W + 1;

  // fixed port widths
  localparam int CFG_W      = 7;
  localparam int SIDX_W     = 6;
  localparam int START_W    = 6;
  localparam int START_CW   = $clog2(START_W);
  localparam int AGENT_W    = 32;
  localparam int FREE_W     = 7;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_REQUEST = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NONE_FREE  = 2'd1,
    ST_UNKNOWN    = 2'd2,
    ST_LOAD_RANGE = 2'd3
  } status_t;

  typedef enum logic {
    ALU_SUB = 1'b0,
    ALU_INC = 1'b1
  } alu_op_t;

  typedef struct packed {
    alu_op_t          op;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] res;
    logic             flag;
  } alu_rsp_t;

endpackage

// ===== rtl/core/rssa_loc_ram.sv =====
`timescale 1ns / 1ps

module rssa_loc_ram (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [rssa_pkg::IDX_W-1:0] wr_addr,
  input  logic [rssa_pkg::LOC_W-1:0] wr_data,
  input  logic [rssa_pkg::IDX_W-1:0] rd_addr,
  output logic [rssa_pkg::LOC_W-1:0] rd_data
);
  import rssa_pkg::*;

  logic [LOC_W-1:0] mem_r [MAX_SLOTS];
  logic [LOC_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/rssa_step_unit.sv =====
`timescale 1ns / 1ps

module rssa_step_unit (
  input  rssa_pkg::alu_req_t req,
  output rssa_pkg::alu_rsp_t rsp
);
  import rssa_pkg::*;

  logic [ALU_W-1:0] operand;
  logic [ALU_W:0]   diff;

  // one incrementer feeding one subtract-compare
  assign operand = (req.op == ALU_INC) ? req.a + ALU_W'(1) : req.a;
  assign diff    = {1'b0, operand} - {1'b0, req.b};

  assign rsp.flag = ~diff[ALU_W];
  assign rsp.res  = (req.op == ALU_SUB) ? diff[ALU_W-1:0] : operand;

endmodule

// ===== rtl/core/random_start_slot_allocator.sv =====
// Random-start slot allocator: a pool of up to 64 slots, each holding a grid location
// (x, y) and a busy mark. A load beat with an index below the slot count writes that
// slot's location and frees it, a request beat scans circularly from start_index
// modulo the slot count and claims the first free slot, a release beat searches the
// slots in index order for a location and frees the lowest match. Every input beat
// gives exactly one result beat, which also carries the number of free slots below the
// slot count. Work is done slot by slot by a small sequencer around one shared
// subtract/compare unit and a location memory with one write port and a registered
// read port, so the block takes one beat at a time. A load or no-op beat goes straight
// to the free-slot recount; a request runs a six-step remainder, the circular scan, a
// memory fetch when a slot is claimed, then the recount; a release reads and compares
// the slots in turn, then recounts. The recount pass over the busy marks ends every
// beat. A finished result sits in an output register, so the next beat is accepted
// while it waits to be taken.
`timescale 1ns / 1ps

module random_start_slot_allocator (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_we,
  input  logic [rssa_pkg::CFG_W-1:0]      cfg_wdata,
  // input channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_cmd,
  input  logic [rssa_pkg::SIDX_W-1:0]     in_slot_index,
  input  logic [rssa_pkg::COORD_BITS-1:0] in_pos_x,
  input  logic [rssa_pkg::COORD_BITS-1:0] in_pos_y,
  input  logic [rssa_pkg::START_W-1:0]    in_start_index,
  input  logic [rssa_pkg::AGENT_W-1:0]    in_requester,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_status,
  output logic [rssa_pkg::SIDX_W-1:0]     out_granted_index,
  output logic [rssa_pkg::COORD_BITS-1:0] out_granted_x,
  output logic [rssa_pkg::COORD_BITS-1:0] out_granted_y,
  output logic [rssa_pkg::AGENT_W-1:0]    out_agent_echo,
  output logic [rssa_pkg::FREE_W-1:0]     out_free_total
);
  import rssa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_REQ_SCAN,
    S_REQ_FETCH,
    S_REL_RD,
    S_REL_CMP,
    S_COUNT,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [CFG_W-1:0]    slot_count_r, slot_count_nxt;
  logic [CNT_W-1:0]    n_eff;

  // busy marks, one flop per slot
  logic [MAX_SLOTS-1:0] busy_r, busy_nxt;

  // working registers for the beat in flight
  logic [IDX_W-1:0]    ptr_r, ptr_nxt;
  logic [CNT_W-1:0]    steps_r, steps_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    rem_r, rem_nxt;
  logic [START_CW-1:0] bit_r, bit_nxt;
  logic [START_W-1:0]  start_r, start_nxt;
  logic [LOC_W-1:0]    key_r, key_nxt;
  status_t             status_r, status_nxt;
  logic [IDX_W-1:0]    gi_r, gi_nxt;
  logic [COORD_BITS-1:0] gx_r, gx_nxt;
  logic [COORD_BITS-1:0] gy_r, gy_nxt;
  logic [AGENT_W-1:0]  echo_r, echo_nxt;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r, out_status_nxt;
  logic [SIDX_W-1:0]     out_gi_r, out_gi_nxt;
  logic [COORD_BITS-1:0] out_gx_r, out_gx_nxt;
  logic [COORD_BITS-1:0] out_gy_r, out_gy_nxt;
  logic [AGENT_W-1:0]    out_echo_r, out_echo_nxt;
  logic [FREE_W-1:0]     out_free_r, out_free_nxt;

  // location memory and shared unit
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  logic [LOC_W-1:0]    wr_data;
  logic [LOC_W-1:0]    rd_data;
  alu_req_t            alu_req;
  alu_rsp_t            alu_rsp;

  rssa_loc_ram u_loc_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (ptr_r),
    .rd_data (rd_data)
  );

  rssa_step_unit u_step_unit (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // count saturates at the pool size
  assign n_eff = (32'(slot_count_r) > MAX_SLOTS) ? CNT_W'(MAX_SLOTS) : CNT_W'(slot_count_r);

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    slot_count_nxt = cfg_we ? cfg_wdata : slot_count_r;
    busy_nxt       = busy_r;
    ptr_nxt        = ptr_r;
    steps_nxt      = steps_r;
    cnt_nxt        = cnt_r;
    rem_nxt        = rem_r;
    bit_nxt        = bit_r;
    start_nxt      = start_r;
    key_nxt        = key_r;
    status_nxt     = status_r;
    gi_nxt         = gi_r;
    gx_nxt         = gx_r;
    gy_nxt         = gy_r;
    echo_nxt       = echo_r;
    out_valid_nxt  = out_valid_r & ~out_ready;
    out_status_nxt = out_status_r;
    out_gi_nxt     = out_gi_r;
    out_gx_nxt     = out_gx_r;
    out_gy_nxt     = out_gy_r;
    out_echo_nxt   = out_echo_r;
    out_free_nxt   = out_free_r;

    wr_en   = 1'b0;
    wr_addr = IDX_W'(in_slot_index);
    wr_data = {in_pos_x, in_pos_y};

    // default use of the unit: step the slot pointer, flag marks the last slot
    alu_req.op = ALU_INC;
    alu_req.a  = ALU_W'(ptr_r);
    alu_req.b  = ALU_W'(n_eff);

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          start_nxt = in_start_index;
          key_nxt   = {in_pos_x, in_pos_y};
          gi_nxt    = '0;
          gx_nxt    = '0;
          gy_nxt    = '0;
          echo_nxt  = '0;
          ptr_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_COUNT;
          unique case (cmd_t'(in_cmd))
            CMD_LOAD: begin
              if (32'(in_slot_index) < 32'(n_eff)) begin
                wr_en = 1'b1;
                busy_nxt[IDX_W'(in_slot_index)] = 1'b0;
                status_nxt = ST_OK;
              end else begin
                status_nxt = ST_LOAD_RANGE;
              end
            end
            CMD_REQUEST: begin
              echo_nxt   = in_requester;
              status_nxt = ST_NONE_FREE;
              if (n_eff != '0) begin
                rem_nxt   = '0;
                bit_nxt   = START_CW'(START_W - 1);
                state_nxt = S_MOD;
              end
            end
            CMD_RELEASE: begin
              status_nxt = ST_UNKNOWN;
              if (n_eff != '0) begin
                state_nxt = S_REL_RD;
              end
            end
            CMD_NOP: begin
              status_nxt = ST_OK;
            end
            default: begin
              status_nxt = ST_OK;
            end
          endcase
        end
      end

      S_MOD: begin
        // restoring remainder, one start bit per cycle
        alu_req.op = ALU_SUB;
        alu_req.a  = {rem_r, start_r[bit_r]};
        rem_nxt    = alu_rsp.flag ? alu_rsp.res[CNT_W-1:0] : alu_req.a[CNT_W-1:0];
        if (bit_r == '0) begin
          ptr_nxt   = IDX_W'(rem_nxt);
          steps_nxt = '0;
          state_nxt = S_REQ_SCAN;
        end else begin
          bit_nxt = bit_r - START_CW'(1);
        end
      end

      S_REQ_SCAN: begin
        if (!busy_r[ptr_r]) begin
          // claim; the memory reads this slot on the same edge
          busy_nxt[ptr_r] = 1'b1;
          status_nxt      = ST_OK;
          gi_nxt          = ptr_r;
          state_nxt       = S_REQ_FETCH;
        end else if ((steps_r + CNT_W'(1)) == n_eff) begin
          ptr_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_COUNT;
        end else begin
          steps_nxt = steps_r + CNT_W'(1);
          ptr_nxt   = alu_rsp.flag ? '0 : IDX_W'(alu_rsp.res);
        end
      end

      S_REQ_FETCH: begin
        gx_nxt    = rd_data[LOC_W-1:COORD_BITS];
        gy_nxt    = rd_data[COORD_BITS-1:0];
        ptr_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = S_COUNT;
      end

      S_REL_RD: begin
        state_nxt = S_REL_CMP;
      end

      S_REL_CMP: begin
        if (rd_data == key_r) begin
          busy_nxt[ptr_r] = 1'b0;
          status_nxt      = ST_OK;
          ptr_nxt         = '0;
          cnt_nxt         = '0;
          state_nxt       = S_COUNT;
        end else if (alu_rsp.flag) begin
          ptr_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_COUNT;
        end else begin
          ptr_nxt   = IDX_W'(alu_rsp.res);
          state_nxt = S_REL_RD;
        end
      end

      S_COUNT: begin
        if (n_eff == '0) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + (busy_r[ptr_r] ? CNT_W'(0) : CNT_W'(1));
          if (alu_rsp.flag) begin
            state_nxt = S_DONE;
          end else begin
            ptr_nxt = IDX_W'(alu_rsp.res);
          end
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_gi_nxt     = SIDX_W'(gi_r);
          out_gx_nxt     = gx_r;
          out_gy_nxt     = gy_r;
          out_echo_nxt   = echo_r;
          out_free_nxt   = FREE_W'(cnt_r);
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      slot_count_r <= '0;
      busy_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      slot_count_r <= slot_count_nxt;
      busy_r       <= busy_nxt;
      out_valid_r  <= out_valid_nxt;
      ptr_r        <= ptr_nxt;
      steps_r      <= steps_nxt;
      cnt_r        <= cnt_nxt;
      rem_r        <= rem_nxt;
      bit_r        <= bit_nxt;
      start_r      <= start_nxt;
      key_r        <= key_nxt;
      status_r     <= status_nxt;
      gi_r         <= gi_nxt;
      gx_r         <= gx_nxt;
      gy_r         <= gy_nxt;
      echo_r       <= echo_nxt;
      out_status_r <= out_status_nxt;
      out_gi_r     <= out_gi_nxt;
      out_gx_r     <= out_gx_nxt;
      out_gy_r     <= out_gy_nxt;
      out_echo_r   <= out_echo_nxt;
      out_free_r   <= out_free_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_granted_index = out_gi_r;
  assign out_granted_x     = out_gx_r;
  assign out_granted_y     = out_gy_r;
  assign out_agent_echo    = out_echo_r;
  assign out_free_total    = out_free_r;

endmodule
